// ===== rtl/mts_pkg.sv =====
// shared types and constants for the max tracking stack
// used by mts_ctrl, mts_datapath, max_tracking_stack_top and mts_checker
package mts_pkg;

   localparam int STACK_DEPTH_DEFAULT = 1024;
   localparam int VALUE_W             = 64;
   localparam int COUNT_OUT_W         = 11;
   localparam int ERR_W               = 2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic capture;  // latch the request fields
      logic exec;     // perform the push or pop
      logic refill;   // load top registers from the memory read
   } mts_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic needs_refill;  // pop that leaves entries behind
   } mts_status_type;

endpackage

// ===== rtl/mts_ctrl.sv =====
// controller state machine for the max tracking stack
// depends on mts_pkg for the command and status structs
module mts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  mts_pkg::mts_status_type status,
   output mts_pkg::mts_cmd_type    cmd
);
   import mts_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_READ = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      busy        = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.needs_refill ? S_READ : S_IDLE;
         end
         S_READ: begin
            cmd.refill = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/mts_datapath.sv =====
// datapath of the max tracking stack: value and running max memories,
// top entry registers, level count and result registers; uses mts_pkg
module mts_datapath #(
   parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mts_pkg::mts_cmd_type               cmd,
   output mts_pkg::mts_status_type            status,
   input  logic                              req_opcode,
   input  logic signed [mts_pkg::VALUE_W-1:0] req_push_value,
   output logic                              rsp_valid,
   output logic signed [mts_pkg::VALUE_W-1:0] rsp_popped_value,
   output logic signed [mts_pkg::VALUE_W-1:0] rsp_current_max,
   output logic [mts_pkg::COUNT_OUT_W-1:0]    rsp_entry_count,
   output logic [mts_pkg::ERR_W-1:0]          rsp_error_code
);
   import mts_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic signed [VALUE_W-1:0] value_mem [STACK_DEPTH];
   logic signed [VALUE_W-1:0] max_mem   [STACK_DEPTH];

   logic                      op_ff;
   logic signed [VALUE_W-1:0] val_ff;
   logic [CW-1:0]             count_ff, count_in;
   logic signed [VALUE_W-1:0] top_val_ff, top_val_in;
   logic signed [VALUE_W-1:0] top_max_ff, top_max_in;
   logic signed [VALUE_W-1:0] rd_val_ff, rd_max_ff;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic signed [VALUE_W-1:0] new_max;
   logic                      is_empty, is_full, more_than_one;
   logic [CW-1:0]             count_m2;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_pop_ff, rsp_pop_in;
   logic signed [VALUE_W-1:0] rsp_max_ff, rsp_max_in;
   logic [CW-1:0]             rsp_cnt_ff, rsp_cnt_in;
   logic [ERR_W-1:0]          rsp_err_ff, rsp_err_in;
   logic [CW+COUNT_OUT_W-1:0] cnt_wide;

   assign is_empty      = (count_ff == '0);
   assign is_full       = (count_ff == CW'(STACK_DEPTH));
   assign more_than_one = (count_ff > CW'(1));
   assign count_m2      = count_ff - CW'(2);
   assign new_max       = (!is_empty && (top_max_ff > val_ff)) ? top_max_ff : val_ff;

   assign status.needs_refill = (op_ff == OP_POP) && more_than_one;

   always_comb begin
      count_in     = count_ff;
      top_val_in   = top_val_ff;
      top_max_in   = top_max_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      rd_en        = 1'b0;
      rd_addr      = count_m2[AW-1:0];
      rsp_valid_in = 1'b0;
      rsp_pop_in   = rsp_pop_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_err_in   = rsp_err_ff;
      if (cmd.exec) begin
         if (op_ff == OP_PUSH) begin
            rsp_valid_in = 1'b1;
            rsp_pop_in   = '0;
            if (is_full) begin
               rsp_err_in = ERR_FULL;
               rsp_max_in = top_max_ff;
               rsp_cnt_in = count_ff;
            end else begin
               wr_en      = 1'b1;
               top_val_in = val_ff;
               top_max_in = new_max;
               count_in   = count_ff + CW'(1);
               rsp_err_in = ERR_OK;
               rsp_max_in = new_max;
               rsp_cnt_in = count_in;
            end
         end else if (is_empty) begin
            rsp_valid_in = 1'b1;
            rsp_err_in   = ERR_EMPTY;
            rsp_pop_in   = '0;
            rsp_max_in   = '0;
            rsp_cnt_in   = '0;
         end else if (!more_than_one) begin
            // last entry leaves, stack empty afterwards
            count_in     = '0;
            rsp_valid_in = 1'b1;
            rsp_err_in   = ERR_OK;
            rsp_pop_in   = top_val_ff;
            rsp_max_in   = '0;
            rsp_cnt_in   = '0;
         end else begin
            // entry below the top must be fetched before responding
            count_in = count_ff - CW'(1);
            rd_en    = 1'b1;
         end
      end
      if (cmd.refill) begin
         top_val_in   = rd_val_ff;
         top_max_in   = rd_max_ff;
         rsp_valid_in = 1'b1;
         rsp_err_in   = ERR_OK;
         rsp_pop_in   = top_val_ff;
         rsp_max_in   = rd_max_ff;
         rsp_cnt_in   = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem[wr_addr] <= val_ff;
         max_mem[wr_addr]   <= new_max;
      end
      if (rd_en) begin
         rd_val_ff <= value_mem[rd_addr];
         rd_max_ff <= max_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_opcode;
         val_ff <= req_push_value;
      end
      top_val_ff <= top_val_in;
      top_max_ff <= top_max_in;
      rsp_pop_ff <= rsp_pop_in;
      rsp_max_ff <= rsp_max_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_err_ff <= rsp_err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign cnt_wide         = {{COUNT_OUT_W{1'b0}}, rsp_cnt_ff};
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_pop_ff;
   assign rsp_current_max  = rsp_max_ff;
   assign rsp_entry_count  = cnt_wide[COUNT_OUT_W-1:0];
   assign rsp_error_code   = rsp_err_ff;

endmodule

// ===== rtl/max_tracking_stack_top.sv =====
// the result strobe is registered from the execute state for a push, an error or a last-entry pop,
//   and from the refill state for a pop that leaves entries behind (registered memory read refills top)
// one request at a time: busy holds off a new start until the result; a new start is taken in the strobe cycle
// results cannot be stalled: each rsp_valid pulse lasts exactly one cycle
// reset: synchronous, active high; clears the level count and control state,
//   the stack memories are not cleared and hold garbage until pushed
module max_tracking_stack_top #(
   parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_opcode,
   input  logic signed [mts_pkg::VALUE_W-1:0] req_push_value,
   // result channel
   output logic                              rsp_valid,
   output logic signed [mts_pkg::VALUE_W-1:0] rsp_popped_value,
   output logic signed [mts_pkg::VALUE_W-1:0] rsp_current_max,
   output logic [mts_pkg::COUNT_OUT_W-1:0]    rsp_entry_count,
   output logic [mts_pkg::ERR_W-1:0]          rsp_error_code
);
   import mts_pkg::*;

   // command and status between controller and datapath
   mts_cmd_type    cmd;
   mts_status_type status;

   // controller: idle, execute, refill from memory
   mts_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // datapath: memories hold every entry, top entry also kept in registers
   // so push max and pop value need no memory read
   mts_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_opcode),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_popped_value (rsp_popped_value),
      .rsp_current_max  (rsp_current_max),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_error_code   (rsp_error_code)
   );

endmodule

// ===== rtl/mts_checker.sv =====
// port level checks for max_tracking_stack_top, attached by bind
// depends on mts_pkg for widths and error codes
module mts_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic signed [mts_pkg::VALUE_W-1:0] rsp_popped_value,
   input logic signed [mts_pkg::VALUE_W-1:0] rsp_current_max,
   input logic [mts_pkg::COUNT_OUT_W-1:0]    rsp_entry_count,
   input logic [mts_pkg::ERR_W-1:0]          rsp_error_code
);
   import mts_pkg::*;

   // a transfer makes the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // a result ends the busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("result strobe outside end of busy period");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code == ERR_OK || rsp_error_code == ERR_EMPTY
                    || rsp_error_code == ERR_FULL)
      else $error("illegal error code");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ERR_EMPTY |->
         rsp_entry_count == '0 && rsp_popped_value == '0 && rsp_current_max == '0)
      else $error("pop on empty reported data");

   a_empty_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_count == '0 |-> rsp_current_max == '0)
      else $error("nonzero max on empty stack");

endmodule

bind max_tracking_stack_top mts_checker u_mts_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_popped_value (rsp_popped_value),
   .rsp_current_max  (rsp_current_max),
   .rsp_entry_count  (rsp_entry_count),
   .rsp_error_code   (rsp_error_code)
);

// ===== test/tb.sv =====
// self-checking testbench for max_tracking_stack_top: mirror or typed rows predict each result
// depends on mts_pkg and the max_tracking_stack_top rtl, nothing else
`timescale 1ns / 1ps

module tb;
   import mts_pkg::*;

   localparam int          DEPTH      = STACK_DEPTH_DEFAULT;
   localparam int          CYCLE_CAP  = 400000;       // generous, slowest run is far below
   localparam int          RAND_ITEMS = 260;          // random transfers per idling phase
   localparam logic [63:0] VMIN       = 64'h8000_0000_0000_0000;
   localparam logic [63:0] VMAX       = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MINUS_ONE  = 64'hFFFF_FFFF_FFFF_FFFF;

   // one result as the block reports it
   typedef struct packed {
      logic [VALUE_W-1:0]     popped;
      logic [VALUE_W-1:0]     top_max;
      logic [COUNT_OUT_W-1:0] count;
      logic [ERR_W-1:0]       err;
   } stack_rsp_type;

   localparam stack_rsp_type NO_EXP = '0;

   // directed row: operation, value, and a hand-typed result where it is obvious
   typedef struct packed {
      logic          op;
      logic [63:0]   value;
      logic          typed;
      stack_rsp_type exp;
   } stack_row_type;

   localparam int NUM_ROWS = 25;

   // after reset: empty pop, extremes, equal maxima, full unwind, then mixed values
   stack_row_type dir_rows [NUM_ROWS] = '{
      '{OP_POP,  64'd0,      1'b1, '{64'd0,     64'd0, 11'd0, ERR_EMPTY}},
      '{OP_PUSH, VMIN,       1'b1, '{64'd0,     VMIN,  11'd1, ERR_OK}},
      '{OP_PUSH, VMAX,       1'b1, '{64'd0,     VMAX,  11'd2, ERR_OK}},
      '{OP_PUSH, MINUS_ONE,  1'b1, '{64'd0,     VMAX,  11'd3, ERR_OK}},
      '{OP_PUSH, 64'd0,      1'b1, '{64'd0,     VMAX,  11'd4, ERR_OK}},
      '{OP_PUSH, VMAX,       1'b1, '{64'd0,     VMAX,  11'd5, ERR_OK}},
      // value field on a pop must be ignored
      '{OP_POP,  64'h5555_5555_5555_5555, 1'b1, '{VMAX, VMAX, 11'd4, ERR_OK}},
      '{OP_POP,  64'd0,      1'b1, '{64'd0,     VMAX,  11'd3, ERR_OK}},
      '{OP_POP,  64'd0,      1'b1, '{MINUS_ONE, VMAX,  11'd2, ERR_OK}},
      '{OP_POP,  64'd0,      1'b1, '{VMAX,      VMIN,  11'd1, ERR_OK}},
      '{OP_POP,  64'd0,      1'b1, '{VMIN,      64'd0, 11'd0, ERR_OK}},
      '{OP_POP,  VMAX,       1'b1, '{64'd0,     64'd0, 11'd0, ERR_EMPTY}},
      '{OP_PUSH, 64'd5,      1'b0, NO_EXP},
      '{OP_PUSH, 64'd3,      1'b0, NO_EXP},
      '{OP_PUSH, 64'd7,      1'b0, NO_EXP},
      '{OP_PUSH, 64'd7,      1'b0, NO_EXP},
      '{OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFB, 1'b0, NO_EXP},
      '{OP_POP,  64'd0,      1'b0, NO_EXP},
      '{OP_POP,  64'd0,      1'b0, NO_EXP},
      '{OP_PUSH, 64'h5555_5555_5555_5555, 1'b0, NO_EXP},
      '{OP_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NO_EXP},
      '{OP_POP,  64'd0,      1'b0, NO_EXP},
      '{OP_POP,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NO_EXP},
      '{OP_POP,  64'd0,      1'b0, NO_EXP},
      '{OP_POP,  64'd0,      1'b0, NO_EXP}
   };

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_opcode;
   logic signed [VALUE_W-1:0] req_push_value;
   logic                      rsp_valid;
   logic signed [VALUE_W-1:0] rsp_popped_value;
   logic signed [VALUE_W-1:0] rsp_current_max;
   logic [COUNT_OUT_W-1:0]    rsp_entry_count;
   logic [ERR_W-1:0]          rsp_error_code;

   // side info travelling with the request, read when the transfer happens
   logic          drv_typed;
   stack_rsp_type drv_exp;

   // mirror of the stack contents, advanced at every request transfer
   logic [VALUE_W-1:0] mirror_vals [DEPTH];
   logic [VALUE_W-1:0] mirror_maxs [DEPTH];
   int                 mirror_level;

   stack_rsp_type results_due [$];   // expected results, oldest first
   int            gap_pct;           // chance per cycle that the sender holds off
   int            fail_count;
   int            cycle_count;

   max_tracking_stack_top #(.STACK_DEPTH(DEPTH)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_popped_value (rsp_popped_value),
      .rsp_current_max  (rsp_current_max),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_error_code   (rsp_error_code)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // apply one operation to the mirror and return what the block should report
   function automatic stack_rsp_type apply_stack_op(input logic op, input logic [63:0] value);
      stack_rsp_type r;
      logic [63:0]   run_max;
      r = '0;
      if (op == OP_PUSH) begin
         if (mirror_level >= DEPTH) begin
            r.err = ERR_FULL;            // dropped, nothing changes
         end else begin
            run_max = value;
            // equal values take the new one, same number either way
            if (mirror_level > 0 && $signed(mirror_maxs[mirror_level-1]) > $signed(value))
               run_max = mirror_maxs[mirror_level-1];
            mirror_vals[mirror_level] = value;
            mirror_maxs[mirror_level] = run_max;
            mirror_level++;
         end
      end else begin
         if (mirror_level == 0) begin
            r.err = ERR_EMPTY;
         end else begin
            mirror_level--;
            r.popped = mirror_vals[mirror_level];
         end
      end
      if (mirror_level > 0)
         r.top_max = mirror_maxs[mirror_level-1];
      r.count = mirror_level[COUNT_OUT_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // result check first, then the new request: a transfer reaches the execute state before the
   // result register is loaded, so a result never belongs to a transfer at the same edge
   always @(posedge clock) begin : scoreboard
      stack_rsp_type got;
      stack_rsp_type want;
      stack_rsp_type predicted;
      if (!reset && rsp_valid) begin
         got = '{rsp_popped_value, rsp_current_max, rsp_entry_count, rsp_error_code};
         if (results_due.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, got);
            fail_count++;
         end else begin
            want = results_due.pop_front();
            check_field("popped_value", want.popped,  got.popped);
            check_field("current_max",  want.top_max, got.top_max);
            check_field("entry_count",  64'(want.count), 64'(got.count));
            check_field("error_code",   64'(want.err),   64'(got.err));
         end
      end
      if (!reset && start && !busy) begin
         // the mirror always advances, even where the row carries a typed result
         predicted   = apply_stack_op(req_opcode, req_push_value);
         results_due = {results_due, (drv_typed ? drv_exp : predicted)};
      end
   end

   // run cap, in case the block stops answering
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_CAP) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // present one request at a falling edge, after random hold-off, and wait for the transfer
   task automatic issue_op(input logic op, input logic [63:0] value, input logic typed,
                           input stack_rsp_type exp);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start          <= 1'b1;
      req_opcode     <= op;
      req_push_value <= value;
      drv_typed      <= typed;
      drv_exp        <= exp;
      do @(posedge clock); while (busy);
   endtask

   // wide random values half the time, with extremes and a narrow band that makes ties common
   function automatic logic [63:0] pick_value();
      int          narrow;
      logic [63:0] v;
      narrow = int'($urandom_range(40)) - 20;
      case ($urandom_range(9))
         0:       v = VMIN;
         1:       v = VMAX;
         2, 3, 4: v = {{32{narrow[31]}}, narrow};
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   // random walk in stretches of push-heavy, balanced and pop-heavy traffic
   task automatic random_walk(input int n);
      int push_pct;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(2))
               0:       push_pct = 75;
               1:       push_pct = 50;
               default: push_pct = 25;
            endcase
         end
         if ($urandom_range(99) < push_pct)
            issue_op(OP_PUSH, pick_value(), 1'b0, NO_EXP);
         else
            issue_op(OP_POP, {$urandom, $urandom}, 1'b0, NO_EXP);
      end
   endtask

   initial begin : stimulus
      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = OP_PUSH;
      req_push_value = '0;
      drv_typed      = 1'b0;
      drv_exp        = NO_EXP;
      mirror_level   = 0;
      fail_count     = 0;
      cycle_count    = 0;
      gap_pct        = 37;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows, sender idles often
      foreach (dir_rows[i])
         issue_op(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].exp);
      random_walk(RAND_ITEMS);

      // sender mostly idle
      gap_pct = 85;
      random_walk(RAND_ITEMS);

      // back to back transfers
      gap_pct = 0;
      random_walk(RAND_ITEMS);

      @(negedge clock);
      start <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      // a few more cycles so a stray extra result is caught
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/mts_pkg.sv
rtl/mts_ctrl.sv
rtl/mts_datapath.sv
rtl/max_tracking_stack_top.sv
rtl/mts_checker.sv
test/tb.sv
